// ===== rtl/core/rrva_pkg.sv =====
`timescale 1ns / 1ps
package rrva_pkg;

   // Table size and derived widths.
   localparam int MAX_TRACK_COUNT = 16;
   localparam int TIDX_W = (MAX_TRACK_COUNT > 1) ? $clog2(MAX_TRACK_COUNT) : 1;
   localparam int CNT_W = $clog2(MAX_TRACK_COUNT + 1);
   localparam int TRACK_W = 5;
   localparam int LT_W = TRACK_W + 1;

   // Front-to-back queue.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Note values.
   localparam logic [6:0] FREE_NOTE = 7'd120;
   localparam logic [6:0] TOP_NOTE = 7'd119;
   localparam logic [6:0] FULL_VELOCITY = 7'd127;

   // Request functions.
   localparam logic FUNC_PLAY = 1'b0;
   localparam logic FUNC_STOP = 1'b1;

   // Velocity mapping modes.
   localparam logic [1:0] VMODE_CMD = 2'd0;
   localparam logic [1:0] VMODE_INSTR = 2'd1;

   // Register indexes.
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_TRACKS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTI_KEY = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_ENABLE = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_FROM = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_TO = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_MODE = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_COMMAND = 4'd7;

   typedef struct packed {
      logic [5:0] num_tracks;
      logic [3:0] octave;
      logic       multi_key;
      logic       vel_enable;
      logic [7:0] vel_from;
      logic [7:0] vel_to;
      logic [1:0] vel_mode;
      logic [7:0] vel_command;
   } cfg_type;

   // One classified request as it waits in the queue.
   typedef struct packed {
      logic       func;
      logic [6:0] note;
      logic [7:0] instr;
      logic [7:0] ins_on;
      logic [7:0] mach;
      logic [7:0] cmd;
      logic [7:0] par;
   } job_type;

   typedef struct packed {
      logic [TRACK_W-1:0] track;
      logic               is_release;
      logic [6:0]         note;
      logic [7:0]         instr;
      logic [7:0]         mach;
      logic [7:0]         cmd;
      logic [7:0]         par;
      logic               last;
   } evt_type;

endpackage

// ===== rtl/core/round_robin_voice_allocator_core.sv =====
`timescale 1ns / 1ps
// Round-robin voice allocator. A request word is taken when start is high and
// busy is low; each request yields zero or more event words on the rsp_ ports,
// each shown for exactly one cycle with rsp_valid high, and the receiver cannot
// stall them, so it must take every word as it appears. The final word of a
// request has rsp_last set; a stop that matches no track yields no words. The
// front stage forms the transposed note and the velocity product as the word
// is taken, finishes the divide by 127 and the clamp in the next cycle and then
// hands the request to a two-entry queue, so busy is high in the cycle after
// each accepted word and stays high while the queue is full. The back end walks
// the track table one track per cycle: a stop makes one release pass over the n
// tracks in use; a play makes that pass, in round-robin mode the modulo steps
// that wrap the start point (one more than the number of times n is subtracted,
// at most MAX_TRACK_COUNT + 1) and the search, then the steal check, a second
// release pass if a note is stolen, and the note-on. Successive requests queue
// up, so the sustained rate is set by this table walk. Reset frees every table
// entry. Configuration registers must only be written while the block is idle.
module round_robin_voice_allocator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_func,
   input  logic [6:0]                     req_note,
   input  logic [6:0]                     req_velocity,
   input  logic                           req_transpose,
   input  logic [7:0]                     req_instrument,
   input  logic [7:0]                     req_machine,
   output logic                           rsp_valid,
   output logic [rrva_pkg::TRACK_W-1:0]   rsp_track,
   output logic                           rsp_is_release,
   output logic [6:0]                     rsp_note_out,
   output logic [7:0]                     rsp_instrument_out,
   output logic [7:0]                     rsp_machine_out,
   output logic [7:0]                     rsp_command,
   output logic [7:0]                     rsp_parameter_res,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rrva_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_wdata
);
   import rrva_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_full, q_push, q_pop, q_valid;
   job_type q_data, q_head;
   evt_type rsp;

   // Registers are always writable; an unknown index is dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_TRACKS:  cfg_in.num_tracks = csr_wdata[5:0];
            CSR_OCTAVE:      cfg_in.octave = csr_wdata[3:0];
            CSR_MULTI_KEY:   cfg_in.multi_key = csr_wdata[0];
            CSR_VEL_ENABLE:  cfg_in.vel_enable = csr_wdata[0];
            CSR_VEL_FROM:    cfg_in.vel_from = csr_wdata;
            CSR_VEL_TO:      cfg_in.vel_to = csr_wdata;
            CSR_VEL_MODE:    cfg_in.vel_mode = csr_wdata[1:0];
            CSR_VEL_COMMAND: cfg_in.vel_command = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_tracks <= 6'd16;
         cfg_ff.octave <= 4'd4;
         cfg_ff.multi_key <= 1'b1;
         cfg_ff.vel_enable <= 1'b0;
         cfg_ff.vel_from <= 8'd0;
         cfg_ff.vel_to <= 8'd255;
         cfg_ff.vel_mode <= VMODE_CMD;
         cfg_ff.vel_command <= 8'd12;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: takes the request word, transposes the note and maps velocity.
   rrva_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_note       (req_note),
      .req_velocity   (req_velocity),
      .req_transpose  (req_transpose),
      .req_instrument (req_instrument),
      .req_machine    (req_machine),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_data)
   );

   // Short queue that lets the front keep taking words during a table walk.
   rrva_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   // Back end: release passes, round-robin search, steal and note-on.
   rrva_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_track = rsp.track;
   assign rsp_is_release = rsp.is_release;
   assign rsp_note_out = rsp.note;
   assign rsp_instrument_out = rsp.instr;
   assign rsp_machine_out = rsp.mach;
   assign rsp_command = rsp.cmd;
   assign rsp_parameter_res = rsp.par;
   assign rsp_last = rsp.last;

   // The flagged word closes a request, and the next request cannot produce a
   // word in the very next cycle.
   a_last_gap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("event word directly after a final word");

   // A note-on is always the final word of its request.
   a_on_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_release |-> rsp_last)
      else $error("note-on word not flagged final");

   // Release words carry no note, command or parameter.
   a_rel_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_release |->
         rsp_note_out == 7'd0 && rsp_command == 8'd0 && rsp_parameter_res == 8'd0)
      else $error("release word carries note data");

   // Every event names a track inside the table.
   a_track_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_track) < 32'(MAX_TRACK_COUNT))
      else $error("event track outside the table");

endmodule

// ===== rtl/core/rrva_front.sv =====
`timescale 1ns / 1ps
module rrva_front (
   input  logic               clock,
   input  logic               reset,
   input  rrva_pkg::cfg_type  cfg,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic [6:0]         req_note,
   input  logic [6:0]         req_velocity,
   input  logic               req_transpose,
   input  logic [7:0]         req_instrument,
   input  logic [7:0]         req_machine,
   input  logic               q_full,
   output logic               q_push,
   output rrva_pkg::job_type  q_data
);
   import rrva_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic              func_ff;
   logic [6:0]        note_ff, note_in;
   logic [6:0]        vel_ff;
   logic [7:0]        instr_ff;
   logic [7:0]        mach_ff;
   logic signed [16:0] prod_ff, prod_in;

   logic              accept;
   logic [8:0]        shifted;
   logic signed [8:0] diff;
   logic [15:0]       mag;
   logic [8:0]        q0;
   logic [9:0]        rem;
   logic [8:0]        quo;
   logic signed [9:0] squo;
   logic signed [10:0] mapped;
   logic [7:0]        par_sat;
   logic              do_map;

   assign busy = s1_valid_ff;
   assign accept = start && !s1_valid_ff;
   assign q_push = s1_valid_ff && !q_full;

   // Octave transpose and clamp; the special notes pass unchanged.
   always_comb begin
      shifted = 9'(req_note) + (req_transpose ? 9'(cfg.octave) * 9'd12 : 9'd0);
      if (req_note < FREE_NOTE) begin
         note_in = (shifted > 9'(TOP_NOTE)) ? TOP_NOTE : shifted[6:0];
      end else begin
         note_in = req_note;
      end
      diff = $signed({1'b0, cfg.vel_to}) - $signed({1'b0, cfg.vel_from});
      prod_in = diff * $signed({1'b0, req_velocity});
   end

   // Second stage: truncating divide by 127 via divide by 128 plus correction.
   always_comb begin
      mag = prod_ff[16] ? 16'(-prod_ff) : 16'(prod_ff);
      q0 = mag[15:7];
      rem = 10'(mag[6:0]) + 10'(q0);
      if (rem >= 10'd254) begin
         quo = q0 + 9'd2;
      end else if (rem >= 10'd127) begin
         quo = q0 + 9'd1;
      end else begin
         quo = q0;
      end
      squo = prod_ff[16] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      mapped = $signed({3'b000, cfg.vel_from}) + 11'(squo);
      if (mapped > 11'sd255) begin
         par_sat = 8'd255;
      end else if (mapped < 11'sd0) begin
         par_sat = 8'd0;
      end else begin
         par_sat = mapped[7:0];
      end
      do_map = (vel_ff != FULL_VELOCITY) && cfg.vel_enable;

      q_data.func = func_ff;
      q_data.note = note_ff;
      q_data.instr = instr_ff;
      q_data.mach = mach_ff;
      q_data.ins_on = instr_ff;
      q_data.cmd = 8'd0;
      q_data.par = 8'd0;
      if (do_map && cfg.vel_mode == VMODE_CMD) begin
         q_data.cmd = cfg.vel_command;
         q_data.par = par_sat;
      end else if (do_map && cfg.vel_mode == VMODE_INSTR) begin
         q_data.ins_on = par_sat;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         note_ff <= note_in;
         vel_ff <= req_velocity;
         instr_ff <= req_instrument;
         mach_ff <= req_machine;
         prod_ff <= prod_in;
      end
   end

endmodule

// ===== rtl/core/rrva_queue.sv =====
`timescale 1ns / 1ps
module rrva_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rrva_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output rrva_pkg::job_type head
);
   import rrva_pkg::*;

   job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/rrva_back.sv =====
`timescale 1ns / 1ps
module rrva_back (
   input  logic              clock,
   input  logic              reset,
   input  rrva_pkg::cfg_type cfg,
   input  logic              q_valid,
   input  rrva_pkg::job_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   output rrva_pkg::evt_type rsp
);
   import rrva_pkg::*;

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_REL = 3'd1;
   localparam logic [2:0] B_MOD = 3'd2;
   localparam logic [2:0] B_SRCH = 3'd3;
   localparam logic [2:0] B_STEAL = 3'd4;
   localparam logic [2:0] B_PLAY = 3'd5;
   localparam logic [2:0] B_FIN = 3'd6;

   logic [2:0]         state_ff, state_in;
   job_type            cur_ff, cur_in;
   logic [TIDX_W-1:0]  idx_ff, idx_in;
   logic [TIDX_W-1:0]  cnt_ff, cnt_in;
   logic [TIDX_W-1:0]  pick_ff, pick_in;
   logic [LT_W-1:0]    r_ff, r_in;
   logic [6:0]         target_ff, target_in;
   logic               second_ff, second_in;
   logic [TRACK_W-1:0] last_track_ff, last_track_in;
   logic [6:0]         tn_ff [MAX_TRACK_COUNT];
   logic               pend_valid_ff, pend_valid_in;
   evt_type            pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   evt_type            rsp_ff, rsp_in;

   logic               tn_we;
   logic [TIDX_W-1:0]  tn_wa;
   logic [6:0]         tn_wd;
   logic [6:0]         rd_note;
   logic [CNT_W-1:0]   ntr;
   logic [CNT_W-1:0]   n_m1;
   logic               at_end;
   logic [TIDX_W-1:0]  idx_wrap;
   logic               emit_v;
   evt_type            emit_e;

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;
   assign q_pop = (state_ff == B_IDLE) && q_valid;
   assign rd_note = tn_ff[idx_ff];

   always_comb begin
      if (cfg.num_tracks == 6'd0) begin
         ntr = CNT_W'(1);
      end else if (cfg.num_tracks > 6'(MAX_TRACK_COUNT)) begin
         ntr = CNT_W'(MAX_TRACK_COUNT);
      end else begin
         ntr = CNT_W'(cfg.num_tracks);
      end
      n_m1 = ntr - 1'b1;
      at_end = (CNT_W'(idx_ff) == n_m1);
      idx_wrap = at_end ? '0 : idx_ff + 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      pick_in = pick_ff;
      r_in = r_ff;
      target_in = target_ff;
      second_in = second_ff;
      last_track_in = last_track_ff;
      tn_we = 1'b0;
      tn_wa = idx_ff;
      tn_wd = FREE_NOTE;
      emit_v = 1'b0;
      emit_e.track = TRACK_W'(idx_ff);
      emit_e.is_release = 1'b1;
      emit_e.note = 7'd0;
      emit_e.instr = cur_ff.instr;
      emit_e.mach = cur_ff.mach;
      emit_e.cmd = 8'd0;
      emit_e.par = 8'd0;
      emit_e.last = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               cur_in = q_head;
               target_in = q_head.note;
               second_in = 1'b0;
               idx_in = '0;
               state_in = B_REL;
            end
         end
         B_REL: begin
            if (rd_note == target_ff) begin
               tn_we = 1'b1;
               emit_v = 1'b1;
            end
            if (!at_end) begin
               idx_in = idx_ff + 1'b1;
            end else if (second_ff) begin
               state_in = B_PLAY;
            end else if (cur_ff.func == FUNC_STOP) begin
               state_in = B_FIN;
            end else if (!cfg.multi_key) begin
               pick_in = '0;
               idx_in = '0;
               state_in = B_STEAL;
            end else begin
               r_in = LT_W'(last_track_ff) + LT_W'(1);
               state_in = B_MOD;
            end
         end
         B_MOD: begin
            if (r_ff >= LT_W'(ntr)) begin
               r_in = r_ff - LT_W'(ntr);
            end else begin
               idx_in = (LT_W'(last_track_ff) < LT_W'(ntr)) ? r_ff[TIDX_W-1:0] : '0;
               cnt_in = '0;
               state_in = B_SRCH;
            end
         end
         B_SRCH: begin
            if (rd_note == FREE_NOTE) begin
               pick_in = idx_ff;
               state_in = B_STEAL;
            end else if (CNT_W'(cnt_ff) == n_m1) begin
               pick_in = r_ff[TIDX_W-1:0];
               idx_in = r_ff[TIDX_W-1:0];
               state_in = B_STEAL;
            end else begin
               idx_in = idx_wrap;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         B_STEAL: begin
            last_track_in = TRACK_W'(pick_ff);
            if (rd_note < FREE_NOTE) begin
               target_in = rd_note;
               second_in = 1'b1;
               idx_in = '0;
               state_in = B_REL;
            end else begin
               state_in = B_PLAY;
            end
         end
         B_PLAY: begin
            tn_we = 1'b1;
            tn_wa = pick_ff;
            tn_wd = cur_ff.note;
            emit_v = 1'b1;
            emit_e.track = TRACK_W'(pick_ff);
            emit_e.is_release = 1'b0;
            emit_e.note = cur_ff.note;
            emit_e.instr = cur_ff.ins_on;
            emit_e.cmd = cur_ff.cmd;
            emit_e.par = cur_ff.par;
            state_in = B_FIN;
         end
         B_FIN: begin
            state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // One event is held back so that the final one can be flagged.
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      if (state_ff == B_FIN) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in = pend_ff;
            rsp_in.last = 1'b1;
         end
         pend_valid_in = 1'b0;
      end else if (emit_v) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in = pend_ff;
            rsp_in.last = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in = emit_e;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         last_track_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_TRACK_COUNT; i++) begin
            tn_ff[i] <= FREE_NOTE;
         end
      end else begin
         state_ff <= state_in;
         last_track_ff <= last_track_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tn_we) begin
            tn_ff[tn_wa] <= tn_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      pick_ff <= pick_in;
      r_ff <= r_in;
      target_ff <= target_in;
      second_ff <= second_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== test/tb_round_robin_voice_allocator_core.sv =====
`timescale 1ns / 1ps
module tb_round_robin_voice_allocator_core;
   import rrva_pkg::*;

   // Clock period, settling time and the run's stall limit. The settling
   // time covers a full front stage and queue of requests that all walk the
   // table without producing an event word, at the slowest walk length.
   localparam int CLOCK_PERIOD = 10;
   localparam int SETTLE_CYCLES = 300;
   localparam int STALL_LIMIT = 3000;
   localparam int RANDOM_PHASES = 6;
   localparam int WORDS_PER_PHASE = 40;
   localparam int SEMITONES = 12;

   // Velocity modes that the package leaves unnamed. The reserved mode acts
   // like the ignore mode.
   localparam logic [1:0] VMODE_IGNORE = 2'd2;
   localparam logic [1:0] VMODE_RESERVED = 2'd3;

   // Register indexes from here up are unused and must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = 4'd8;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_func = FUNC_PLAY;
   logic [6:0]           req_note = '0;
   logic [6:0]           req_velocity = '0;
   logic                 req_transpose = 1'b0;
   logic [7:0]           req_instrument = '0;
   logic [7:0]           req_machine = '0;
   logic                 rsp_valid;
   logic [TRACK_W-1:0]   rsp_track;
   logic                 rsp_is_release;
   logic [6:0]           rsp_note_out;
   logic [7:0]           rsp_instrument_out;
   logic [7:0]           rsp_machine_out;
   logic [7:0]           rsp_command;
   logic [7:0]           rsp_parameter_res;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]           csr_wdata = '0;

   round_robin_voice_allocator_core u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_note           (req_note),
      .req_velocity       (req_velocity),
      .req_transpose      (req_transpose),
      .req_instrument     (req_instrument),
      .req_machine        (req_machine),
      .rsp_valid          (rsp_valid),
      .rsp_track          (rsp_track),
      .rsp_is_release     (rsp_is_release),
      .rsp_note_out       (rsp_note_out),
      .rsp_instrument_out (rsp_instrument_out),
      .rsp_machine_out    (rsp_machine_out),
      .rsp_command        (rsp_command),
      .rsp_parameter_res  (rsp_parameter_res),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Shadow of the allocator: the register settings, the note held on each
   // track and the track that was handed out last.
   cfg_type            settings;
   logic [6:0]         held_note [MAX_TRACK_COUNT];
   logic [TRACK_W-1:0] recent_track;

   // Event words still owed by the block, oldest first, and the words that the
   // request being predicted produces.
   evt_type expected_events [$];
   evt_type new_events [$];
   evt_type next_event;

   int mismatch_count = 0;
   int stall_cycles = 0;
   int gap_limit = 0;

   // The register value is clipped into the size of the table, and a zero
   // counts as one track.
   function automatic int tracks_in_use();
      int n;
      n = int'(settings.num_tracks);
      if (n == 0) n = 1;
      if (n > MAX_TRACK_COUNT) n = MAX_TRACK_COUNT;
      return n;
   endfunction

   // Regular notes move up by whole octaves and saturate at the top note.
   // The special notes from the free marker upward pass through untouched.
   function automatic logic [6:0] shifted_note(logic [6:0] note, logic transpose);
      int value;
      value = int'(note);
      if (note < FREE_NOTE) begin
         if (transpose) value += int'(settings.octave) * SEMITONES;
         if (value > int'(TOP_NOTE)) value = int'(TOP_NOTE);
      end
      return value[6:0];
   endfunction

   // Frees every track in use that holds the note and owes a release word for
   // each of them, in track order.
   task automatic release_matching(logic [6:0] note, logic [7:0] instr, logic [7:0] mach);
      evt_type ev;
      for (int i = 0; i < tracks_in_use(); i++) begin
         if (held_note[i] == note) begin
            held_note[i] = FREE_NOTE;
            ev = '0;
            ev.track = TRACK_W'(i);
            ev.is_release = 1'b1;
            ev.instr = instr;
            ev.mach = mach;
            new_events.push_back(ev);
         end
      end
   endtask

   // Round-robin search for a free track, starting just after the track that
   // was used last and wrapping around. A stale last track beyond the tracks
   // in use makes the second pass cover all of them. With no free track
   // the next track in turn is taken and its note stolen.
   function automatic int pick_track();
      int n;
      int stop_at;
      n = tracks_in_use();
      if (!settings.multi_key) return 0;
      for (int i = int'(recent_track) + 1; i < n; i++)
         if (held_note[i] == FREE_NOTE) return i;
      stop_at = (int'(recent_track) < n) ? int'(recent_track) : n - 1;
      for (int i = 0; i <= stop_at; i++)
         if (held_note[i] == FREE_NOTE) return i;
      return (int'(recent_track) + 1) % n;
   endfunction

   // Works out every event word that one accepted request causes and queues
   // them, the final one marked as last.
   task automatic predict_request(logic func, logic [6:0] note, logic [6:0] vel,
                                  logic transpose, logic [7:0] instr, logic [7:0] mach);
      logic [6:0] played;
      logic [7:0] cmd;
      logic [7:0] par;
      logic [7:0] ins;
      int         mapped;
      int         chosen;
      evt_type    ev;
      played = shifted_note(note, transpose);
      cmd = '0;
      par = '0;
      ins = instr;
      new_events.delete();
      // Both a play and a stop first release the note wherever it is held.
      release_matching(played, instr, mach);
      if (func == FUNC_PLAY) begin
         // Linear velocity map between the two end values; the division
         // truncates toward zero.
         if (vel != FULL_VELOCITY && settings.vel_enable) begin
            mapped = int'(settings.vel_from) +
                     (int'(settings.vel_to) - int'(settings.vel_from)) * int'(vel) /
                     int'(FULL_VELOCITY);
            if (mapped > 255) mapped = 255;
            if (mapped < 0) mapped = 0;
            if (settings.vel_mode == VMODE_CMD) begin
               cmd = settings.vel_command;
               par = mapped[7:0];
            end else if (settings.vel_mode == VMODE_INSTR) begin
               ins = mapped[7:0];
            end
         end
         chosen = pick_track();
         recent_track = TRACK_W'(chosen);
         // A regular note still on the chosen track is stolen as it is
         // stored, so it is not transposed a second time.
         if (held_note[chosen] < FREE_NOTE)
            release_matching(held_note[chosen], instr, mach);
         held_note[chosen] = played;
         ev = '0;
         ev.track = TRACK_W'(chosen);
         ev.note = played;
         ev.instr = ins;
         ev.mach = mach;
         ev.cmd = cmd;
         ev.par = par;
         new_events.push_back(ev);
      end
      foreach (new_events[k]) begin
         ev = new_events[k];
         ev.last = (k == new_events.size() - 1);
         expected_events.push_back(ev);
      end
   endtask

   // Offers one request word after a random pause and holds it until the
   // block takes it. The start line stays high when the next word follows at
   // once, so it is never dropped and raised in the same step.
   task automatic send_request(logic func, logic [6:0] note, logic [6:0] vel,
                               logic transpose, logic [7:0] instr, logic [7:0] mach);
      int gap;
      gap = $urandom_range(0, gap_limit);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= func;
      req_note <= note;
      req_velocity <= vel;
      req_transpose <= transpose;
      req_instrument <= instr;
      req_machine <= mach;
      do @(posedge clock); while (busy);
      predict_request(func, note, vel, transpose, instr, mach);
   endtask

   // Stops offering requests until every owed event word has come out.
   task automatic wait_for_events();
      start <= 1'b0;
      do @(posedge clock); while (expected_events.size() != 0);
   endtask

   // Brings the block to rest: requests that produce no word may still be
   // walking the table after the last word, so a settling time follows.
   task automatic settle_block();
      wait_for_events();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register and mirrors it in the shadow settings. Writes to an
   // unused index leave the settings alone.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_NUM_TRACKS: settings.num_tracks = value[5:0];
         CSR_OCTAVE: settings.octave = value[3:0];
         CSR_MULTI_KEY: settings.multi_key = value[0];
         CSR_VEL_ENABLE: settings.vel_enable = value[0];
         CSR_VEL_FROM: settings.vel_from = value;
         CSR_VEL_TO: settings.vel_to = value;
         CSR_VEL_MODE: settings.vel_mode = value[1:0];
         CSR_VEL_COMMAND: settings.vel_command = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_settings(logic [5:0] tracks, logic [3:0] octave, logic multi,
                                logic vel_on, logic [7:0] from, logic [7:0] to,
                                logic [1:0] mode, logic [7:0] command);
      write_reg(CSR_NUM_TRACKS, 8'(tracks));
      write_reg(CSR_OCTAVE, 8'(octave));
      write_reg(CSR_MULTI_KEY, 8'(multi));
      write_reg(CSR_VEL_ENABLE, 8'(vel_on));
      write_reg(CSR_VEL_FROM, from);
      write_reg(CSR_VEL_TO, to);
      write_reg(CSR_VEL_MODE, 8'(mode));
      write_reg(CSR_VEL_COMMAND, command);
   endtask

   // Settings straight out of reset: sixteen tracks, octave four, round-robin
   // search and no velocity mapping. Covers the note extremes, transposition
   // with clamping, a play that first frees its own note, a stop with nothing
   // to release and a stop of the free marker, which releases every free track.
   task automatic test_reset_settings();
      gap_limit = 9;
      send_request(FUNC_PLAY, 7'd0, FULL_VELOCITY, 1'b0, 8'hFF, 8'h00);
      send_request(FUNC_PLAY, 7'h7F, 7'd0, 1'b1, 8'h00, 8'hFF);
      send_request(FUNC_PLAY, 7'd100, 7'd50, 1'b1, 8'h3C, 8'hC3);
      send_request(FUNC_PLAY, TOP_NOTE, 7'd1, 1'b0, 8'h81, 8'h18);
      send_request(FUNC_STOP, 7'd0, 7'h55, 1'b0, 8'h5A, 8'hA5);
      send_request(FUNC_STOP, 7'd55, 7'h2A, 1'b1, 8'h12, 8'h34);
      send_request(FUNC_STOP, FREE_NOTE, 7'd0, 1'b1, 8'h77, 8'h88);
      send_request(FUNC_STOP, 7'h7F, FULL_VELOCITY, 1'b0, 8'h01, 8'h80);
      settle_block();
   endtask

   // Velocity mapping in each mode, at both ends of the velocity range and
   // with the map running upward and downward. Full velocity is never mapped.
   task automatic test_velocity_mapping();
      gap_limit = 0;
      write_reg(CSR_VEL_ENABLE, 8'd1);
      write_reg(CSR_VEL_FROM, 8'd0);
      write_reg(CSR_VEL_TO, 8'd255);
      write_reg(CSR_VEL_MODE, 8'(VMODE_CMD));
      write_reg(CSR_VEL_COMMAND, 8'hA5);
      send_request(FUNC_PLAY, 7'd60, 7'd0, 1'b0, 8'h10, 8'h20);
      send_request(FUNC_PLAY, 7'd61, 7'd126, 1'b0, 8'h11, 8'h21);
      send_request(FUNC_PLAY, 7'd62, FULL_VELOCITY, 1'b0, 8'h12, 8'h22);
      settle_block();
      write_reg(CSR_VEL_FROM, 8'd255);
      write_reg(CSR_VEL_TO, 8'd0);
      write_reg(CSR_VEL_MODE, 8'(VMODE_INSTR));
      send_request(FUNC_PLAY, 7'd63, 7'd64, 1'b0, 8'h13, 8'h23);
      settle_block();
      write_reg(CSR_VEL_MODE, 8'(VMODE_IGNORE));
      send_request(FUNC_PLAY, 7'd64, 7'd10, 1'b0, 8'h14, 8'h24);
      settle_block();
      write_reg(CSR_VEL_MODE, 8'(VMODE_RESERVED));
      send_request(FUNC_PLAY, 7'd65, 7'd10, 1'b0, 8'h15, 8'h25);
      settle_block();
   endtask

   // Track count handling: zero acts as one track, counts above the table
   // saturate, a full table forces a steal, a shrunken count leaves the last
   // track out of range, and single-key mode always lands on track zero.
   // A write to an unused register index must change nothing.
   task automatic test_track_limits();
      gap_limit = 9;
      write_reg(CSR_MULTI_KEY, 8'd1);
      write_reg(CSR_NUM_TRACKS, 8'd0);
      send_request(FUNC_PLAY, 7'd10, 7'd90, 1'b0, 8'h31, 8'h41);
      send_request(FUNC_PLAY, 7'd11, 7'd91, 1'b0, 8'h32, 8'h42);
      settle_block();
      write_reg(CSR_NUM_TRACKS, 8'd32);
      write_reg(CSR_IDX_W'($urandom_range({CSR_IDX_W{1'b1}}, CSR_FIRST_UNUSED)),
                8'($urandom_range(0, 255)));
      send_request(FUNC_PLAY, 7'd23, 7'd92, 1'b1, 8'h33, 8'h43);
      settle_block();
      write_reg(CSR_NUM_TRACKS, 8'd1);
      send_request(FUNC_PLAY, 7'd25, 7'd93, 1'b0, 8'h34, 8'h44);
      settle_block();
      write_reg(CSR_NUM_TRACKS, 8'd2);
      send_request(FUNC_PLAY, 7'd20, 7'd94, 1'b0, 8'h35, 8'h45);
      send_request(FUNC_PLAY, 7'd21, 7'd95, 1'b0, 8'h36, 8'h46);
      send_request(FUNC_PLAY, 7'd22, 7'd96, 1'b0, 8'h37, 8'h47);
      settle_block();
      write_reg(CSR_NUM_TRACKS, 8'd16);
      write_reg(CSR_MULTI_KEY, 8'd0);
      send_request(FUNC_PLAY, 7'd30, 7'd97, 1'b0, 8'h38, 8'h48);
      send_request(FUNC_PLAY, 7'd31, 7'd98, 1'b0, 8'h39, 8'h49);
      send_request(FUNC_STOP, 7'd31, 7'd99, 1'b0, 8'h3A, 8'h4A);
      settle_block();
   endtask

   // Random traffic in several phases of settings. Most words form a sensible
   // key stream: plays of random notes and stops of notes that are actually
   // held, so the table fills, wraps and steals. The rest is noise. The first
   // two phases pin the register extremes, and some phases send back to back.
   task automatic test_random_traffic();
      int         pick;
      logic       func;
      logic [6:0] note;
      logic       transpose;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)
            load_settings(6'd1, 4'd0, 1'b1, 1'b1, 8'd0, 8'd255, VMODE_CMD, 8'd0);
         else if (phase == 1)
            load_settings(6'd32, 4'd9, 1'b1, 1'b1, 8'd255, 8'd0, VMODE_INSTR, 8'd255);
         else
            load_settings(6'($urandom_range(0, 32)), 4'($urandom_range(0, 9)),
                          $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         gap_limit = (phase % 3 == 1) ? 0 : 9;
         for (int w = 0; w < WORDS_PER_PHASE; w++) begin
            pick = $urandom_range(0, 99);
            transpose = 1'($urandom_range(0, 1));
            if (pick < 55) begin
               func = FUNC_PLAY;
               note = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(FREE_NOTE, 7'h7F))
                                                  : 7'($urandom_range(0, TOP_NOTE));
            end else if (pick < 90) begin
               // Stop a note that some track holds; a free track mostly turns
               // into a stop of a random regular note instead.
               func = FUNC_STOP;
               transpose = 1'b0;
               note = held_note[$urandom_range(0, tracks_in_use() - 1)];
               if (note == FREE_NOTE && $urandom_range(0, 3) != 0)
                  note = 7'($urandom_range(0, TOP_NOTE));
            end else begin
               func = 1'($urandom_range(0, 1));
               note = 7'($urandom_range(0, 7'h7F));
            end
            send_request(func, note, 7'($urandom_range(0, 7'h7F)), transpose,
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            // Now and then hold the sender until the block has caught up.
            if ($urandom_range(0, 39) == 0) wait_for_events();
         end
         settle_block();
      end
   endtask

   // Every event word is taken in the cycle it is shown and compared with the
   // oldest word still owed.
   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_events.size() == 0) begin
            $error("event word on track %0d with none owed", rsp_track);
            mismatch_count++;
         end else begin
            next_event = expected_events.pop_front();
            check_field("track", 8'(next_event.track), 8'(rsp_track));
            check_field("is_release", 8'(next_event.is_release), 8'(rsp_is_release));
            check_field("note_out", 8'(next_event.note), 8'(rsp_note_out));
            check_field("instrument_out", next_event.instr, rsp_instrument_out);
            check_field("machine_out", next_event.mach, rsp_machine_out);
            check_field("command", next_event.cmd, rsp_command);
            check_field("parameter_res", next_event.par, rsp_parameter_res);
            check_field("last", 8'(next_event.last), 8'(rsp_last));
         end
      end
   end

   // Ends the run when no word of any kind has moved for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("round_robin_voice_allocator_core verification failed");
            $finish;
         end
      end
   end

   initial begin
      // The shadow starts from the reset state of the block.
      foreach (held_note[i]) held_note[i] = FREE_NOTE;
      recent_track = '0;
      settings.num_tracks = 6'd16;
      settings.octave = 4'd4;
      settings.multi_key = 1'b1;
      settings.vel_enable = 1'b0;
      settings.vel_from = 8'd0;
      settings.vel_to = 8'd255;
      settings.vel_mode = VMODE_CMD;
      settings.vel_command = 8'd12;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_velocity_mapping();
      test_track_limits();
      test_random_traffic();
      if (mismatch_count == 0 && expected_events.size() == 0) begin
         $display("round_robin_voice_allocator_core verification clean");
      end else begin
         $display("round_robin_voice_allocator_core verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/rrva_pkg.sv
rtl/core/rrva_front.sv
rtl/core/rrva_queue.sv
rtl/core/rrva_back.sv
rtl/core/round_robin_voice_allocator_core.sv
test/tb_round_robin_voice_allocator_core.sv
